/* rtl/srg_pkg.sv */
// Shared types and constants for the servo ramp generator.
// No dependencies; imported by every other file of the block.
package srg_pkg;

  localparam int CHANNELS    = 6;
  localparam int CHAN_W      = 3;
  localparam int WIDTH_W     = 12;
  localparam int DUR_W       = 16;
  localparam int TICK_W      = 10;
  localparam int DELTA_W     = WIDTH_W + 1;
  localparam int STEPS_W     = DUR_W + 1;
  localparam int DIV_W       = 16;
  localparam int DIV_CNT_W   = $clog2(DIV_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [WIDTH_W-1:0] INIT_WIDTH  = 12'd1500;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX   = 12'd4095;
  localparam logic [TICK_W-1:0]  TICK_RESET  = 10'd20;

  localparam logic KIND_MOVE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [PADDR_W-3:0] REG_TICK_PERIOD = '0;

  typedef struct packed {
    logic                kind;
    logic [CHAN_W-1:0]   channel;
    logic [DUR_W-1:0]    duration_ms;
    logic [WIDTH_W-1:0]  target_width;
  } op_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

endpackage

/* rtl/srg_cmd_if.sv */
// Command channel: valid/ready handshake with move and tick items.
// Depends on srg_pkg.
interface srg_cmd_if;
  import srg_pkg::*;

  logic               valid;
  logic               ready;
  logic               kind;
  logic [CHAN_W-1:0]  channel;
  logic [DUR_W-1:0]   duration_ms;
  logic [WIDTH_W-1:0] target_width;

  modport source (output valid, kind, channel, duration_ms, target_width, input ready);
  modport sink   (input valid, kind, channel, duration_ms, target_width, output ready);
endinterface

/* rtl/srg_res_if.sv */
// Result channel: valid/ready handshake carrying a channel's new pulse width.
// Depends on srg_pkg.
interface srg_res_if;
  import srg_pkg::*;

  logic               valid;
  logic               ready;
  logic [CHAN_W-1:0]  out_channel;
  logic [WIDTH_W-1:0] pulse_width;

  modport source (output valid, out_channel, pulse_width, input ready);
  modport sink   (input valid, out_channel, pulse_width, output ready);
endinterface

/* rtl/servo_ramp_generator.sv */
// Six-channel servo pulse-width ramp generator, top level with the register port.
// Depends on srg_pkg, srg_cmd_if, srg_res_if, srg_front and srg_back.
//
//   port      dir   handshake            payload
//   cmd       in    valid/ready          kind, channel, duration_ms, target_width
//   result    out   valid/ready          out_channel, pulse_width
//   apb       in    psel/penable/pready  paddr, pwdata, prdata (tick_period_ms at 0x0)
//
// A tick is handled in the back end from the idle state; a move takes two passes
// through the 16-bit serial divider (steps, then per-step increment); only the first
// when the step count is zero, none when the tick period is zero.
// A two-entry queue parts accept from execution; a stalled result holds further ticks.
// Synchronous reset: every channel at the initial width, no ramp active, tick period 20.
module servo_ramp_generator (
  input  logic                         clk,
  input  logic                         rst,
  srg_cmd_if.sink                      cmd,
  srg_res_if.source                    result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [srg_pkg::PADDR_W-1:0]  paddr,
  input  logic [srg_pkg::PDATA_W-1:0]  pwdata,
  output logic [srg_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import srg_pkg::*;

  logic [TICK_W-1:0] tick_period_ms;
  logic              q_valid;
  op_t               q_op;
  logic              q_pop;
  logic              reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = paddr[PADDR_W-1:2] == REG_TICK_PERIOD;
  assign prdata  = reg_hit ? PDATA_W'(tick_period_ms) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period_ms <= TICK_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      tick_period_ms <= pwdata[TICK_W-1:0];
    end
  end

  srg_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .q_valid (q_valid),
    .q_op    (q_op),
    .q_pop   (q_pop)
  );

  srg_back u_back (
    .clk            (clk),
    .rst            (rst),
    .tick_period_ms (tick_period_ms),
    .q_valid        (q_valid),
    .q_op           (q_op),
    .q_pop          (q_pop),
    .result         (result)
  );

endmodule

/* rtl/srg_front.sv */
// Front end: accepts command items, drops out-of-range channels and queues the rest.
// Depends on srg_pkg and srg_cmd_if.
module srg_front (
  input  logic           clk,
  input  logic           rst,
  srg_cmd_if.sink        cmd,
  output logic           q_valid,
  output srg_pkg::op_t   q_op,
  input  logic           q_pop
);
  import srg_pkg::*;

  op_t               q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              chan_ok;
  logic              push;
  op_t               push_op;

  assign chan_ok   = int'(cmd.channel) < CHANNELS;
  assign cmd.ready = count != QCNT_W'(QUEUE_DEPTH);
  assign push      = cmd.valid && cmd.ready && chan_ok;
  assign push_op   = '{kind: cmd.kind, channel: cmd.channel,
                       duration_ms: cmd.duration_ms, target_width: cmd.target_width};
  assign q_valid   = count != '0;
  assign q_op      = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        q_mem[wr_ptr] <= push_op;
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count past depth");

  a_drop_bad_chan: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready && !chan_ok && !q_pop) |=> count == $past(count))
    else $error("out-of-range channel entered queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> count != '0)
    else $error("pop from empty queue");

endmodule

/* rtl/srg_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on srg_pkg.
module srg_div (
  input  logic              clk,
  input  logic              rst,
  input  srg_pkg::div_req_t req,
  output srg_pkg::div_rsp_t rsp
);
  import srg_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     quo;
  logic [DIV_W-1:0]     dvs;
  logic [DIV_W:0]       rem_sh;
  logic [DIV_W:0]       trial;
  logic                 ge;

  assign rem_sh = {rem, quo[DIV_W-1]};
  assign trial  = rem_sh - {1'b0, dvs};
  assign ge     = !trial[DIV_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W - 1);
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
      end else if (busy) begin
        rem <= ge ? trial[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done, quotient: quo, remainder: rem};

endmodule

/* rtl/srg_back.sv */
// Back end: per-channel ramp state, move setup through the divider, tick stepping
// and the result register. Depends on srg_pkg, srg_res_if and srg_div.
module srg_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [srg_pkg::TICK_W-1:0]  tick_period_ms,
  input  logic                        q_valid,
  input  srg_pkg::op_t                q_op,
  output logic                        q_pop,
  srg_res_if.source                   result
);
  import srg_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV_STEPS, S_DIV_SPLIT} state_t;

  state_t                    state;
  logic [WIDTH_W-1:0]        cur       [CHANNELS];
  logic                      active    [CHANNELS];
  logic [STEPS_W-1:0]        steps_left[CHANNELS];
  logic signed [DELTA_W-1:0] step_amt  [CHANNELS];
  logic signed [DELTA_W-1:0] final_rem [CHANNELS];
  logic [CHAN_W-1:0]         mv_ch;
  logic signed [DELTA_W-1:0] mv_diff;
  logic [DIV_W-1:0]          mv_steps;
  logic                      out_valid;
  logic [CHAN_W-1:0]         out_ch;
  logic [WIDTH_W-1:0]        out_pw;

  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  logic [CHAN_W-1:0]         ch;
  logic                      is_tick;
  logic                      out_free;
  logic                      emit;
  logic signed [DELTA_W-1:0] diff_now;
  logic signed [DELTA_W-1:0] add_sel;
  logic signed [DELTA_W:0]   sum;
  logic [WIDTH_W-1:0]        clamped;
  logic                      mv_neg;
  logic [DELTA_W-1:0]        mag;
  logic [DELTA_W-1:0]        q_mag;
  logic [DELTA_W-1:0]        r_mag;
  logic signed [DELTA_W-1:0] q_signed;
  logic signed [DELTA_W-1:0] r_signed;
  logic                      bad_state;

  srg_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  assign ch       = q_op.channel;
  assign is_tick  = q_op.kind == KIND_TICK;
  assign out_free = !out_valid || result.ready;
  assign q_pop    = (state == S_IDLE) && q_valid && (!is_tick || out_free);
  assign emit     = q_pop && is_tick && active[ch] && (steps_left[ch] != '0);

  assign diff_now = $signed({1'b0, q_op.target_width}) - $signed({1'b0, cur[ch]});
  assign add_sel  = (steps_left[ch] > STEPS_W'(1)) ? step_amt[ch] : final_rem[ch];
  assign sum      = $signed({2'b00, cur[ch]}) + {add_sel[DELTA_W-1], add_sel};

  always_comb begin
    if (sum < 0) begin
      clamped = '0;
    end else if (sum > $signed({2'b00, WIDTH_MAX})) begin
      clamped = WIDTH_MAX;
    end else begin
      clamped = sum[WIDTH_W-1:0];
    end
  end

  assign mv_neg   = mv_diff[DELTA_W-1];
  assign mag      = mv_neg ? DELTA_W'(-mv_diff) : mv_diff;
  assign q_mag    = div_rsp.quotient[DELTA_W-1:0];
  assign r_mag    = div_rsp.remainder[DELTA_W-1:0];
  assign q_signed = mv_neg ? -$signed(q_mag) : $signed(q_mag);
  assign r_signed = mv_neg ? -$signed(r_mag) : $signed(r_mag);

  always_comb begin
    div_req.start = (q_pop && !is_tick && (tick_period_ms != '0))
                 || ((state == S_DIV_STEPS) && div_rsp.done && (div_rsp.quotient != '0));
    if (state == S_IDLE) begin
      div_req.dividend = q_op.duration_ms;
      div_req.divisor  = DIV_W'(tick_period_ms);
    end else begin
      div_req.dividend = DIV_W'(mag);
      div_req.divisor  = div_rsp.quotient;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        cur[i]        <= INIT_WIDTH;
        active[i]     <= 1'b0;
        steps_left[i] <= '0;
        step_amt[i]   <= '0;
        final_rem[i]  <= '0;
      end
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        out_ch    <= ch;
        out_pw    <= clamped;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (is_tick) begin
              if (active[ch]) begin
                if (steps_left[ch] != '0) begin
                  steps_left[ch] <= steps_left[ch] - 1'b1;
                  cur[ch]        <= clamped;
                end else begin
                  active[ch]   <= 1'b0;
                  step_amt[ch] <= '0;
                end
              end
            end else begin
              mv_ch   <= ch;
              mv_diff <= diff_now;
              if (tick_period_ms == '0) begin
                active[ch]     <= 1'b1;
                step_amt[ch]   <= '0;
                final_rem[ch]  <= diff_now;
                steps_left[ch] <= STEPS_W'(1);
              end else begin
                state <= S_DIV_STEPS;
              end
            end
          end
        end
        S_DIV_STEPS: begin
          if (div_rsp.done) begin
            mv_steps <= div_rsp.quotient;
            if (div_rsp.quotient == '0) begin
              active[mv_ch]     <= 1'b1;
              step_amt[mv_ch]   <= '0;
              final_rem[mv_ch]  <= mv_diff;
              steps_left[mv_ch] <= STEPS_W'(1);
              state             <= S_IDLE;
            end else begin
              state <= S_DIV_SPLIT;
            end
          end
        end
        S_DIV_SPLIT: begin
          if (div_rsp.done) begin
            active[mv_ch]     <= 1'b1;
            step_amt[mv_ch]   <= q_signed;
            final_rem[mv_ch]  <= r_signed;
            steps_left[mv_ch] <= {1'b0, mv_steps} + 1'b1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid       = out_valid;
  assign result.out_channel = out_ch;
  assign result.pulse_width = out_pw;

  always_comb begin
    bad_state = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if ((steps_left[i] != '0) && !active[i]) begin
        bad_state = 1'b1;
      end
    end
  end

  a_steps_need_active: assert property (@(posedge clk) disable iff (rst)
    !bad_state)
    else $error("steps pending on inactive channel");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV_STEPS || state == S_DIV_SPLIT))
    else $error("divider finished outside a move");

  a_split_steps: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_SPLIT && div_rsp.done) |=> steps_left[mv_ch] > STEPS_W'(1))
    else $error("split move left fewer than two steps");

  a_emit_from_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_IDLE)
    else $error("result produced outside tick handling");

endmodule

/* tb/servo_ramp_generator_test.sv */
`timescale 1ns / 100ps
// Testbench for servo_ramp_generator: a directed table, then random move/tick traffic
// over several tick periods, each result checked against an in-bench ramp predictor.
// Depends on srg_pkg, srg_cmd_if, srg_res_if and the servo_ramp_generator RTL.
module servo_ramp_generator_test;
  import srg_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 300;
  localparam int PHASES        = 5;
  localparam int PHASE_ITEMS   = 255;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 100;
  localparam int MAX_REPORTS   = 10;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_act_t;
  typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_WIDTH} chk_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  chan;
    logic [WIDTH_W-1:0] width;
  } width_rec_t;

  typedef struct {
    row_act_t           act;
    op_t                op;
    logic [TICK_W-1:0]  period;
    chk_t               chk;
    logic [WIDTH_W-1:0] width;
  } row_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  srg_cmd_if cmd_bus();
  srg_res_if res_bus();

  servo_ramp_generator dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_bus),
    .result(res_bus),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // predicted ramp state
  logic [TICK_W-1:0]  tick_period;
  logic [WIDTH_W-1:0] cur_width  [CHANNELS];
  logic               ramp_on    [CHANNELS];
  logic [STEPS_W-1:0] steps_left [CHANNELS];
  int                 step_inc   [CHANNELS];
  int                 last_inc   [CHANNELS];

  width_rec_t width_q[$];
  row_t       dir_rows[$];

  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  int moves_sent = 0;
  int ticks_sent = 0;
  int ignored_sent = 0;
  int cfg_writes = 0;
  int cycles = 0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;
  bit hold_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d widths pending", cycles, width_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic void flag_error(input string what);
    errors++;
    if (errors <= MAX_REPORTS) $display("[%0t] %s", $time, what);
  endfunction

  function automatic logic [WIDTH_W-1:0] clamp_width(input int w);
    if (w < 0) return '0;
    if (w > int'(WIDTH_MAX)) return WIDTH_MAX;
    return WIDTH_W'(w);
  endfunction

  function automatic void ramp_reset();
    tick_period = TICK_RESET;
    for (int i = 0; i < CHANNELS; i++) begin
      cur_width[i]  = INIT_WIDTH;
      ramp_on[i]    = 1'b0;
      steps_left[i] = '0;
      step_inc[i]   = 0;
      last_inc[i]   = 0;
    end
  endfunction

  // Returns 1 when a tick steps an active channel, which yields a result.
  function automatic bit ramp_apply(input op_t op, output width_rec_t rec);
    int ch;
    int diff;
    int steps;
    ch = op.channel;
    rec = '0;
    if (ch >= CHANNELS) return 1'b0;
    if (op.kind == KIND_MOVE) begin
      diff = int'(op.target_width) - int'(cur_width[ch]);
      steps = (tick_period == '0) ? 0 : int'(op.duration_ms) / int'(tick_period);
      ramp_on[ch] = 1'b1;
      if (steps == 0) begin
        step_inc[ch] = 0;
        last_inc[ch] = diff;
      end else begin
        step_inc[ch] = diff / steps;
        last_inc[ch] = diff % steps;
      end
      steps_left[ch] = STEPS_W'(steps + 1);
      return 1'b0;
    end
    if (!ramp_on[ch]) return 1'b0;
    if (steps_left[ch] > 1) begin
      steps_left[ch] = steps_left[ch] - 1'b1;
      cur_width[ch] = clamp_width(int'(cur_width[ch]) + step_inc[ch]);
    end else if (steps_left[ch] == 1) begin
      steps_left[ch] = '0;
      cur_width[ch] = clamp_width(int'(cur_width[ch]) + last_inc[ch]);
    end else begin
      ramp_on[ch] = 1'b0;
      step_inc[ch] = 0;
      return 1'b0;
    end
    rec.chan = op.channel;
    rec.width = cur_width[ch];
    return 1'b1;
  endfunction

  function automatic row_t item_row(input logic kind, input int chan, input int dur,
                                    input int tgt, input chk_t chk, input int width);
    row_t r;
    r.act = ROW_ITEM;
    r.op.kind = kind;
    r.op.channel = CHAN_W'(chan);
    r.op.duration_ms = DUR_W'(dur);
    r.op.target_width = WIDTH_W'(tgt);
    r.period = '0;
    r.chk = chk;
    r.width = WIDTH_W'(width);
    return r;
  endfunction

  function automatic row_t cfg_row(input int period);
    row_t r;
    r = item_row(KIND_TICK, 0, 0, 0, CHK_NONE, 0);
    r.act = ROW_CFG;
    r.period = TICK_W'(period);
    return r;
  endfunction

  function automatic op_t random_op();
    op_t op;
    int per;
    int d;
    int r;
    per = tick_period;
    op.kind = ($urandom_range(0, 3) == 0) ? KIND_MOVE : KIND_TICK;
    if ($urandom_range(0, 15) == 0)
      op.channel = CHAN_W'($urandom_range(CHANNELS, (1 << CHAN_W) - 1));
    else
      op.channel = CHAN_W'($urandom_range(0, CHANNELS - 1));
    if (per == 0 || $urandom_range(0, 9) == 0) begin
      op.duration_ms = DUR_W'($urandom);
    end else begin
      // mostly short ramps so that they run to the end
      d = per * $urandom_range(0, 6) + $urandom_range(0, per - 1);
      if (d > (1 << DUR_W) - 1) d = (1 << DUR_W) - 1;
      op.duration_ms = DUR_W'(d);
    end
    r = $urandom_range(0, 9);
    if (r == 0) op.target_width = '0;
    else if (r == 1) op.target_width = WIDTH_MAX;
    else op.target_width = WIDTH_W'($urandom);
    return op;
  endfunction

  task automatic send_op(input op_t op, input chk_t chk, input logic [WIDTH_W-1:0] width);
    int gap;
    bit hit;
    width_rec_t rec;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid        <= 1'b1;
    cmd_bus.kind         <= op.kind;
    cmd_bus.channel      <= op.channel;
    cmd_bus.duration_ms  <= op.duration_ms;
    cmd_bus.target_width <= op.target_width;
    do @(posedge clk); while (cmd_bus.ready !== 1'b1);
    hit = ramp_apply(op, rec);
    case (chk)
      CHK_PRED: begin
        if (hit) width_q.push_back(rec);
      end
      CHK_WIDTH: begin
        rec.chan = op.channel;
        rec.width = width;
        width_q.push_back(rec);
      end
      default: ;
    endcase
    items_sent++;
    if (op.channel >= CHANNELS) ignored_sent++;
    else if (op.kind == KIND_MOVE) moves_sent++;
    else ticks_sent++;
  endtask

  task automatic drain();
    cmd_bus.valid <= 1'b0;
    while (width_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(input logic [TICK_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TICK_PERIOD, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tick_period = value;
    cfg_writes++;
  endtask

  task automatic run_random(input int count);
    int n;
    op_t op;
    n = 0;
    while (n < count) begin
      op = random_op();
      if (op.channel < CHANNELS) n++;
      send_op(op, CHK_PRED, '0);
    end
  endtask

  initial begin : result_sink
    int stall;
    width_rec_t want;
    res_bus.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 15);
      // one long hold-off so the queue fills and the command side stalls
      if (!hold_done && items_sent >= HOLD_AFTER) begin
        hold_done = 1'b1;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk); while (res_bus.valid !== 1'b1);
      results_seen++;
      if (width_q.size() == 0) begin
        flag_error($sformatf("unexpected width: ch %0d width %0d",
                             res_bus.out_channel, res_bus.pulse_width));
      end else begin
        want = width_q.pop_front();
        if (res_bus.out_channel !== want.chan)
          flag_error($sformatf("out_channel: expected %0d, got %0d",
                               want.chan, res_bus.out_channel));
        if (res_bus.pulse_width !== want.width)
          flag_error($sformatf("pulse_width ch %0d: expected %0d, got %0d",
                               want.chan, want.width, res_bus.pulse_width));
      end
    end
  end

  initial begin : stimulus
    logic [TICK_W-1:0] plan [PHASES];
    rst                  <= 1'b1;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    cmd_bus.valid        <= 1'b0;
    cmd_bus.kind         <= KIND_MOVE;
    cmd_bus.channel      <= '0;
    cmd_bus.duration_ms  <= '0;
    cmd_bus.target_width <= '0;
    ramp_reset();

    // idle after reset
    dir_rows.push_back(item_row(KIND_TICK, 0, 0, 0, CHK_NONE, 0));
    // zero duration: single jump, then the following tick deactivates
    dir_rows.push_back(item_row(KIND_MOVE, 0, 0, 4095, CHK_NONE, 0));
    dir_rows.push_back(item_row(KIND_TICK, 0, 0, 0, CHK_WIDTH, 4095));
    dir_rows.push_back(item_row(KIND_TICK, 0, 0, 0, CHK_NONE, 0));
    dir_rows.push_back(item_row(KIND_TICK, 0, 0, 0, CHK_NONE, 0));
    // duration just under one tick
    dir_rows.push_back(item_row(KIND_MOVE, 5, 19, 0, CHK_NONE, 0));
    dir_rows.push_back(item_row(KIND_TICK, 5, 0, 0, CHK_WIDTH, 0));
    // channels past the last one are ignored
    dir_rows.push_back(item_row(KIND_MOVE, 6, 100, 7, CHK_NONE, 0));
    dir_rows.push_back(item_row(KIND_TICK, 7, 65535, 4095, CHK_NONE, 0));
    // three steps of one, then a restart mid-ramp
    dir_rows.push_back(item_row(KIND_MOVE, 1, 60, 1503, CHK_NONE, 0));
    dir_rows.push_back(item_row(KIND_TICK, 1, 0, 0, CHK_WIDTH, 1501));
    dir_rows.push_back(item_row(KIND_MOVE, 1, 65535, 0, CHK_NONE, 0));
    dir_rows.push_back(item_row(KIND_TICK, 1, 0, 0, CHK_PRED, 0));
    dir_rows.push_back(cfg_row(1));
    // negative ramp with a remainder
    dir_rows.push_back(item_row(KIND_MOVE, 2, 3, 1490, CHK_NONE, 0));
    dir_rows.push_back(item_row(KIND_TICK, 2, 0, 0, CHK_PRED, 0));
    dir_rows.push_back(item_row(KIND_TICK, 2, 0, 0, CHK_PRED, 0));
    dir_rows.push_back(item_row(KIND_TICK, 2, 0, 0, CHK_PRED, 0));
    dir_rows.push_back(item_row(KIND_TICK, 2, 0, 0, CHK_WIDTH, 1490));
    dir_rows.push_back(item_row(KIND_TICK, 2, 0, 0, CHK_NONE, 0));
    // longest step count
    dir_rows.push_back(item_row(KIND_MOVE, 3, 65535, 4095, CHK_NONE, 0));
    dir_rows.push_back(item_row(KIND_TICK, 3, 0, 0, CHK_PRED, 0));
    dir_rows.push_back(cfg_row(1000));
    dir_rows.push_back(item_row(KIND_MOVE, 4, 999, 2000, CHK_NONE, 0));
    dir_rows.push_back(item_row(KIND_TICK, 4, 0, 0, CHK_WIDTH, 2000));
    dir_rows.push_back(item_row(KIND_MOVE, 4, 65535, 0, CHK_NONE, 0));
    dir_rows.push_back(item_row(KIND_TICK, 4, 0, 0, CHK_PRED, 0));
    // zero tick period: every move is a jump
    dir_rows.push_back(cfg_row(0));
    dir_rows.push_back(item_row(KIND_MOVE, 0, 65535, 0, CHK_NONE, 0));
    dir_rows.push_back(item_row(KIND_TICK, 0, 0, 0, CHK_WIDTH, 0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].act == ROW_CFG) begin
        drain();
        write_period(dir_rows[i].period);
      end else begin
        send_op(dir_rows[i].op, dir_rows[i].chk, dir_rows[i].width);
      end
    end

    plan[0] = TICK_RESET;
    plan[1] = TICK_W'(1);
    plan[2] = TICK_W'(1000);
    plan[3] = TICK_W'($urandom_range(2, 999));
    plan[4] = '0;
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_period(plan[p]);
      run_random(PHASE_ITEMS);
    end
    drain();

    $display("Sent %0d moves, %0d ticks and %0d ignored items over %0d tick-period writes",
             moves_sent, ticks_sent, ignored_sent, cfg_writes);
    $display("Checked %0d pulse widths, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
